/* src/assert_macros.svh */
// assertion macros for the highpass compressor limiter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HCL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hcl assertion failed");

// next-cycle implication
`define HCL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hcl assertion failed");

// delayed implication
`define HCL_ASSERT_D2(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##2 (cons)) \
        else $error("hcl assertion failed");

`else

`define HCL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HCL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define HCL_ASSERT_D2(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/hcl_pkg.sv */
// shared types, constants and microprogram for the highpass compressor limiter
`default_nettype none

package hcl_pkg;

    localparam int FRAC_BITS_DEF = 23;

    localparam int STEP_W       = 5;
    localparam int QUO_W        = 17;
    localparam int GAIN_W       = 20;
    localparam int CNT_W        = 5;
    localparam int ROUND_SHIFT  = 16;
    localparam int MAKEUP_SHIFT = 12;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(32'h10000);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUO_W - 1);

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               frame_end;
    } in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               frame_end_out;
    } out_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] hpf_alpha;
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic [15:0] threshold;
        logic [15:0] inv_ratio;
        logic [15:0] makeup_gain;
        logic [15:0] limit_level;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:        1'b0,
        hpf_alpha:     16'd64523,
        attack_coeff:  16'd65535,
        release_coeff: 16'd65535,
        threshold:     16'd32768,
        inv_ratio:     16'd65535,
        makeup_gain:   16'd4096,
        limit_level:   16'd32768
    };

    typedef enum logic [2:0] {
        CFG_ENABLE,
        CFG_HPF_ALPHA,
        CFG_ATTACK,
        CFG_RELEASE,
        CFG_THRESHOLD,
        CFG_INV_RATIO,
        CFG_MAKEUP,
        CFG_LIMIT
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_DIFF,
        OP_MUL_HPF,
        OP_HPF_Y,
        OP_ENV_D,
        OP_MUL_ENV,
        OP_ENV_UPD,
        OP_MUL_RATIO,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_MAKEUP,
        OP_GAIN_MK,
        OP_MUL_OUT,
        OP_OUT_CLAMP,
        OP_OUT_SCALE,
        OP_EMIT,
        OP_PASS
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_WAIT_IN,
        COND_DIS,
        COND_NOT_OVER,
        COND_LOOP,
        COND_QUIET,
        COND_EMIT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic not_over;
        logic div_more;
        logic quiet;
    } dp_flags_t;

    typedef struct packed {
        logic      take;
        logic      disabled;
        logic      out_free;
        dp_flags_t dp;
    } status_t;

    localparam step_t STEP_IDLE     = 5'd0;
    localparam step_t STEP_CHECK    = 5'd1;
    localparam step_t STEP_HPF_MUL  = 5'd2;
    localparam step_t STEP_HPF_Y    = 5'd3;
    localparam step_t STEP_ENV_D    = 5'd4;
    localparam step_t STEP_ENV_MUL  = 5'd5;
    localparam step_t STEP_ENV_UPD  = 5'd6;
    localparam step_t STEP_RATIO    = 5'd7;
    localparam step_t STEP_DIV_INIT = 5'd8;
    localparam step_t STEP_DIV      = 5'd9;
    localparam step_t STEP_FLOOR    = 5'd10;
    localparam step_t STEP_MK_MUL   = 5'd11;
    localparam step_t STEP_MK_GAIN  = 5'd12;
    localparam step_t STEP_OUT_MUL  = 5'd13;
    localparam step_t STEP_CLAMP    = 5'd14;
    localparam step_t STEP_SCALE    = 5'd15;
    localparam step_t STEP_EMIT     = 5'd16;
    localparam step_t STEP_PASS     = 5'd17;

    function automatic ctrl_word_t prog_word(input step_t s);
        ctrl_word_t w;
        case (s)
            STEP_IDLE:     w = '{OP_NOP,        COND_WAIT_IN,  STEP_IDLE};
            STEP_CHECK:    w = '{OP_DIFF,       COND_DIS,      STEP_PASS};
            STEP_HPF_MUL:  w = '{OP_MUL_HPF,    COND_NEXT,     STEP_IDLE};
            STEP_HPF_Y:    w = '{OP_HPF_Y,      COND_NEXT,     STEP_IDLE};
            STEP_ENV_D:    w = '{OP_ENV_D,      COND_NEXT,     STEP_IDLE};
            STEP_ENV_MUL:  w = '{OP_MUL_ENV,    COND_NEXT,     STEP_IDLE};
            STEP_ENV_UPD:  w = '{OP_ENV_UPD,    COND_NEXT,     STEP_IDLE};
            STEP_RATIO:    w = '{OP_MUL_RATIO,  COND_NEXT,     STEP_IDLE};
            STEP_DIV_INIT: w = '{OP_DIV_INIT,   COND_NOT_OVER, STEP_FLOOR};
            STEP_DIV:      w = '{OP_DIV_STEP,   COND_LOOP,     STEP_DIV};
            STEP_FLOOR:    w = '{OP_NOP,        COND_QUIET,    STEP_OUT_MUL};
            STEP_MK_MUL:   w = '{OP_MUL_MAKEUP, COND_NEXT,     STEP_IDLE};
            STEP_MK_GAIN:  w = '{OP_GAIN_MK,    COND_NEXT,     STEP_IDLE};
            STEP_OUT_MUL:  w = '{OP_MUL_OUT,    COND_NEXT,     STEP_IDLE};
            STEP_CLAMP:    w = '{OP_OUT_CLAMP,  COND_NEXT,     STEP_IDLE};
            STEP_SCALE:    w = '{OP_OUT_SCALE,  COND_NEXT,     STEP_IDLE};
            STEP_EMIT:     w = '{OP_EMIT,       COND_EMIT,     STEP_IDLE};
            STEP_PASS:     w = '{OP_PASS,       COND_EMIT,     STEP_IDLE};
            default:       w = '{OP_NOP,        COND_JUMP,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/hcl_sequencer.sv */
// microprogram step counter and control word table
`default_nettype none

module hcl_sequencer (
    input  wire                    clk,
    input  wire                    rst_n,
    input  hcl_pkg::status_t       status,
    output hcl_pkg::ctrl_word_t    ctrl,
    output hcl_pkg::step_t         step
);

    hcl_pkg::step_t pc_reg;
    hcl_pkg::step_t pc_next;
    hcl_pkg::step_t pc_inc;

    assign ctrl   = hcl_pkg::prog_word(pc_reg);
    assign step   = pc_reg;
    assign pc_inc = pc_reg + 1'b1;

    always_comb
    begin
        case (ctrl.cond)
            hcl_pkg::COND_NEXT:     pc_next = pc_inc;
            hcl_pkg::COND_JUMP:     pc_next = ctrl.target;
            hcl_pkg::COND_WAIT_IN:  pc_next = status.take ? pc_inc : pc_reg;
            hcl_pkg::COND_DIS:      pc_next = status.disabled ? ctrl.target : pc_inc;
            hcl_pkg::COND_NOT_OVER: pc_next = status.dp.not_over ? ctrl.target : pc_inc;
            hcl_pkg::COND_LOOP:     pc_next = status.dp.div_more ? ctrl.target : pc_inc;
            hcl_pkg::COND_QUIET:    pc_next = status.dp.quiet ? ctrl.target : pc_inc;
            hcl_pkg::COND_EMIT:     pc_next = status.out_free ? ctrl.target : pc_reg;
            default:                pc_next = hcl_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= hcl_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

/* src/hcl_datapath.sv */
// filter, envelope, gain divider and output scaling datapath
`default_nettype none

module hcl_datapath #(
    parameter int STATE_FRAC_BITS = hcl_pkg::FRAC_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  hcl_pkg::op_t         op,
    input  wire                  take,
    input  hcl_pkg::in_t         in_data,
    input  hcl_pkg::cfg_t        cfg,
    output hcl_pkg::dp_flags_t   flags,
    output hcl_pkg::out_t        result
);

    localparam int F    = STATE_FRAC_BITS;
    localparam int SH   = F - 15;
    localparam int X_W  = F + 1;
    localparam int Y_W  = F + 4;
    localparam int E_W  = F + 3;
    localparam int A_W  = F + 5;
    localparam int B_W  = hcl_pkg::GAIN_W + 1;
    localparam int P_W  = A_W + B_W;
    localparam int R_W  = P_W - hcl_pkg::ROUND_SHIFT;
    localparam int L_W  = F + 1;
    localparam int N_W  = F + 19;
    localparam int Q_W  = hcl_pkg::QUO_W;
    localparam int O_W  = F + 2;
    localparam int S_W  = F + 17;
    localparam int G_W  = hcl_pkg::GAIN_W;

    localparam logic [E_W-1:0] NOISE_FLOOR =
        E_W'(((64'd1 << (F + 1)) + 64'd50) / 64'd100);
    localparam logic signed [R_W-1:0] Y_HI = R_W'(64'sd1 <<< (F + 2));
    localparam logic signed [R_W-1:0] Y_LO = -Y_HI;
    localparam logic signed [P_W-1:0] HALF =
        P_W'(64'sd1 <<< (hcl_pkg::ROUND_SHIFT - 1));

    logic signed [15:0]      sample_reg;
    logic                    frame_reg;
    logic signed [X_W-1:0]   last_input_reg;
    logic signed [Y_W-1:0]   last_filtered_reg;
    logic [E_W-1:0]          env_reg;
    logic [hcl_pkg::CNT_W-1:0] cnt_reg;
    logic signed [A_W-1:0]   a_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic [G_W-1:0]          gain_reg;
    logic [E_W-1:0]          rem_reg;
    logic [Q_W-1:0]          quo_reg;
    logic signed [O_W-1:0]   o_reg;
    logic signed [S_W-1:0]   sc_reg;

    logic signed [X_W-1:0]   x_val;
    logic [L_W-1:0]          t_val;
    logic [L_W-1:0]          lim_val;
    logic signed [P_W-1:0]   rsum;
    logic signed [R_W-1:0]   rnd;
    logic signed [Y_W-1:0]   y_sat;
    logic signed [Y_W-1:0]   y_abs;
    logic [E_W-1:0]          absy;
    logic signed [A_W-1:0]   diff_val;
    logic signed [A_W-1:0]   env_d;
    logic signed [A_W-1:0]   over_d;
    logic signed [R_W-1:0]   env_sum;
    logic [N_W-1:0]          num;
    logic [E_W:0]            rem_sh;
    logic [E_W:0]            rem_dif;
    logic                    div_ge;
    logic [Q_W-1:0]          quo_new;
    logic signed [R_W-1:0]   lim_r;
    logic signed [R_W-1:0]   o_r;
    logic signed [S_W-1:0]   sc_val;
    logic [S_W-1:0]          mag_full;
    logic [16:0]             mag;
    logic signed [15:0]      smp;
    logic signed [A_W-1:0]   ma;
    logic signed [B_W-1:0]   mb;
    logic signed [P_W-1:0]   prod_next;
    logic                    env_over;
    logic                    env_loud;

    assign x_val   = X_W'(sample_reg) <<< SH;
    assign t_val   = L_W'(cfg.threshold) << SH;
    assign lim_val = L_W'(cfg.limit_level) << SH;

    // round to nearest, ties up, after the q0.16 product
    assign rsum = prod_reg + HALF;
    assign rnd  = $signed(rsum[P_W-1:hcl_pkg::ROUND_SHIFT]);

    assign y_sat = Y_W'((rnd > Y_HI) ? Y_HI : ((rnd < Y_LO) ? Y_LO : rnd));
    assign y_abs = last_filtered_reg[Y_W-1] ? -last_filtered_reg : last_filtered_reg;
    assign absy  = y_abs[E_W-1:0];

    assign diff_val = A_W'(last_filtered_reg) + A_W'(x_val) - A_W'(last_input_reg);
    assign env_d    = A_W'($signed({1'b0, absy})) - A_W'($signed({1'b0, env_reg}));
    assign over_d   = A_W'($signed({1'b0, env_reg})) - A_W'($signed({1'b0, t_val}));
    assign env_sum  = R_W'($signed({1'b0, env_reg})) + rnd;

    assign env_over = env_reg > E_W'(t_val);
    assign env_loud = env_reg > NOISE_FLOOR;

    // quotient fits in QUO_W bits, so the upper part starts below the divisor
    assign num     = (N_W'(t_val) << 16) + prod_reg[N_W-1:0];
    assign rem_sh  = {rem_reg, quo_reg[Q_W-1]};
    assign div_ge  = rem_sh >= {1'b0, env_reg};
    assign rem_dif = rem_sh - {1'b0, env_reg};
    assign quo_new = {quo_reg[Q_W-2:0], div_ge};

    assign lim_r = R_W'($signed({1'b0, lim_val}));
    assign o_r   = (rnd > lim_r) ? lim_r : ((rnd < -lim_r) ? -lim_r : rnd);

    // times 32767 as a shift and subtract
    assign sc_val = (S_W'(o_reg) <<< 15) - S_W'(o_reg);

    assign mag_full = sc_reg[S_W-1] ? S_W'(-sc_reg) : S_W'(sc_reg);
    assign mag      = mag_full[S_W-1:F];

    always_comb
    begin
        if (!sc_reg[S_W-1])
        begin
            smp = (mag > 17'd32767) ? 16'sh7FFF : $signed(mag[15:0]);
        end
        else
        begin
            smp = (mag > 17'd32768) ? 16'sh8000 : $signed(16'(17'd0 - mag));
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        ma = a_reg;
        mb = '0;
        case (op)
            hcl_pkg::OP_MUL_HPF:
            begin
                mb = B_W'($signed({1'b0, cfg.hpf_alpha}));
            end
            hcl_pkg::OP_MUL_ENV:
            begin
                mb = a_reg[A_W-1] ? B_W'($signed({1'b0, cfg.release_coeff}))
                                  : B_W'($signed({1'b0, cfg.attack_coeff}));
            end
            hcl_pkg::OP_MUL_RATIO:
            begin
                ma = over_d;
                mb = B_W'($signed({1'b0, cfg.inv_ratio}));
            end
            hcl_pkg::OP_MUL_MAKEUP:
            begin
                ma = A_W'($signed({1'b0, gain_reg}));
                mb = B_W'($signed({1'b0, cfg.makeup_gain}));
            end
            hcl_pkg::OP_MUL_OUT:
            begin
                ma = A_W'(last_filtered_reg);
                mb = B_W'($signed({1'b0, gain_reg}));
            end
            default:
            begin
                ma = a_reg;
                mb = '0;
            end
        endcase
    end

    assign prod_next = ma * mb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_input_reg    <= '0;
            last_filtered_reg <= '0;
            env_reg           <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            case (op)
                hcl_pkg::OP_HPF_Y:
                begin
                    last_input_reg    <= x_val;
                    last_filtered_reg <= y_sat;
                end
                hcl_pkg::OP_ENV_UPD:
                begin
                    env_reg <= env_sum[E_W-1:0];
                end
                hcl_pkg::OP_DIV_INIT:
                begin
                    cnt_reg <= hcl_pkg::DIV_LAST;
                end
                hcl_pkg::OP_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= in_data.sample_in;
            frame_reg  <= in_data.frame_end;
        end
        case (op)
            hcl_pkg::OP_DIFF:
            begin
                a_reg <= diff_val;
            end
            hcl_pkg::OP_ENV_D:
            begin
                a_reg <= env_d;
            end
            hcl_pkg::OP_MUL_HPF, hcl_pkg::OP_MUL_ENV, hcl_pkg::OP_MUL_RATIO,
            hcl_pkg::OP_MUL_MAKEUP, hcl_pkg::OP_MUL_OUT:
            begin
                prod_reg <= prod_next;
            end
            hcl_pkg::OP_DIV_INIT:
            begin
                rem_reg  <= E_W'(num[N_W-1:Q_W]);
                quo_reg  <= num[Q_W-1:0];
                gain_reg <= hcl_pkg::GAIN_ONE;
            end
            hcl_pkg::OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? rem_dif[E_W-1:0] : rem_sh[E_W-1:0];
                quo_reg <= quo_new;
                if (cnt_reg == '0)
                begin
                    gain_reg <= G_W'(quo_new);
                end
            end
            hcl_pkg::OP_GAIN_MK:
            begin
                gain_reg <= prod_reg[hcl_pkg::MAKEUP_SHIFT +: G_W];
            end
            hcl_pkg::OP_OUT_CLAMP:
            begin
                o_reg <= O_W'(o_r);
            end
            hcl_pkg::OP_OUT_SCALE:
            begin
                sc_reg <= sc_val;
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    assign flags.not_over = !env_over;
    assign flags.div_more = cnt_reg != '0;
    assign flags.quiet    = !env_loud;

    assign result.sample_out    = (op == hcl_pkg::OP_PASS) ? sample_reg : smp;
    assign result.frame_end_out = frame_reg;

endmodule

`default_nettype wire

/* src/highpass_compressor_limiter_top.sv */
// top level of the highpass compressor limiter
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  hcl_pkg::in_t  (sample_in, frame_end)
//  out      output     out_valid/out_stall  hcl_pkg::out_t (sample_out, frame_end_out)
//  cfg      input      cfg_we               cfg_index, cfg_data
//
//  a processed sample runs the filter, envelope and gain steps; the 17-step restoring
//  divider for the compression gain runs only while the envelope is above the threshold
//  a bypassed sample goes from the check step straight to the pass step
//  a new request is taken once the previous result sits in the output register
//  the output register holds its result while out_stall is high
//  reset clears the configuration to defaults and the filter and envelope state
`default_nettype none

`include "assert_macros.svh"

module highpass_compressor_limiter_top #(
    parameter int STATE_FRAC_BITS = hcl_pkg::FRAC_BITS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_stall,
    input  hcl_pkg::in_t   in_data,
    output logic           out_valid,
    input  wire            out_stall,
    output hcl_pkg::out_t  out_data,
    input  wire            cfg_we,
    input  wire [2:0]      cfg_index,
    input  wire [15:0]     cfg_data
);

    hcl_pkg::cfg_t       cfg_reg;
    hcl_pkg::cfg_t       cfg_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    hcl_pkg::out_t       out_data_reg;
    hcl_pkg::ctrl_word_t ctrl;
    hcl_pkg::step_t      step;
    hcl_pkg::status_t    status;
    hcl_pkg::dp_flags_t  dp_flags;
    hcl_pkg::out_t       dp_result;
    logic                in_take;
    logic                out_free;
    logic                out_write;

    assign in_stall  = ctrl.cond != hcl_pkg::COND_WAIT_IN;
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_write = (ctrl.cond == hcl_pkg::COND_EMIT) && out_free;

    assign status.take     = in_take;
    assign status.disabled = !cfg_reg.enable;
    assign status.out_free = out_free;
    assign status.dp       = dp_flags;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (hcl_pkg::cfg_idx_t'(cfg_index))
                hcl_pkg::CFG_ENABLE:    cfg_next.enable        = cfg_data[0];
                hcl_pkg::CFG_HPF_ALPHA: cfg_next.hpf_alpha     = cfg_data;
                hcl_pkg::CFG_ATTACK:    cfg_next.attack_coeff  = cfg_data;
                hcl_pkg::CFG_RELEASE:   cfg_next.release_coeff = cfg_data;
                hcl_pkg::CFG_THRESHOLD: cfg_next.threshold     = cfg_data;
                hcl_pkg::CFG_INV_RATIO: cfg_next.inv_ratio     = cfg_data;
                hcl_pkg::CFG_MAKEUP:    cfg_next.makeup_gain   = cfg_data;
                hcl_pkg::CFG_LIMIT:     cfg_next.limit_level   = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= hcl_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_write)
        begin
            out_data_reg <= dp_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    hcl_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .step   (step)
    );

    hcl_datapath #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (ctrl.op),
        .take    (in_take),
        .in_data (in_data),
        .cfg     (cfg_reg),
        .flags   (dp_flags),
        .result  (dp_result)
    );

    `HCL_ASSERT_NXT(a_take_starts, clk, rst_n, in_take, step == hcl_pkg::STEP_CHECK)
    `HCL_ASSERT_D2(a_bypass_path, clk, rst_n, in_take && !cfg_reg.enable, step == hcl_pkg::STEP_PASS)
    `HCL_ASSERT_D2(a_filter_path, clk, rst_n, in_take && cfg_reg.enable, step == hcl_pkg::STEP_HPF_MUL)
    `HCL_ASSERT_NXT(a_emit_waits, clk, rst_n, (ctrl.cond == hcl_pkg::COND_EMIT) && !out_free, $stable(step))

endmodule

`default_nettype wire

/* verif/highpass_compressor_limiter_top_test.sv */
// testbench for the highpass compressor limiter: predicts and checks every result
module highpass_compressor_limiter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    FRAC        = hcl_pkg::FRAC_BITS_DEF;
    localparam longint UNIT       = longint'(1) << (FRAC - 15);
    localparam longint Y_MAX      = longint'(1) << (FRAC + 2);
    localparam longint NOISE_FLOOR = ((longint'(1) << (FRAC + 1)) + 50) / 100;
    localparam int    CYCLE_LIMIT = 600000;
    localparam int    SETTLE_CYCLES = 40;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    hcl_pkg::in_t   in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    hcl_pkg::out_t  out_data;
    logic           cfg_we = 1'b0;
    logic [2:0]     cfg_index = '0;
    logic [15:0]    cfg_data = '0;

    // predictor copy of registers and filter state
    hcl_pkg::cfg_t cur_cfg = hcl_pkg::CFG_RESET;
    longint prev_x = 0;
    longint prev_y = 0;
    longint env_level = 0;

    hcl_pkg::out_t expected_q[$];
    int   fail_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_left = 0;

    highpass_compressor_limiter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("highpass_compressor_limiter_top regression: fail");
            $finish;
        end
    end

    // receiver stall, with a counted hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic hcl_pkg::out_t process_sample(input hcl_pkg::in_t item);
        longint x, y, absy, d, coeff, gain, t, num, o, lim, scaled;
        hcl_pkg::out_t r;
        r.frame_end_out = item.frame_end;
        if (!cur_cfg.enable)
        begin
            r.sample_out = item.sample_in;
            return r;
        end
        x = longint'(item.sample_in) * UNIT;
        y = round_q16(longint'(cur_cfg.hpf_alpha) * (prev_y + x - prev_x));
        if (y > Y_MAX)
            y = Y_MAX;
        else if (y < -Y_MAX)
            y = -Y_MAX;
        prev_x = x;
        prev_y = y;

        absy = (y < 0) ? -y : y;
        d = absy - env_level;
        coeff = (absy > env_level) ? longint'(cur_cfg.attack_coeff)
                                   : longint'(cur_cfg.release_coeff);
        env_level = env_level + round_q16(d * coeff);

        gain = longint'(1) << 16;
        t = longint'(cur_cfg.threshold) * UNIT;
        if (env_level > t)
        begin
            num = t * 65536 + (env_level - t) * longint'(cur_cfg.inv_ratio);
            gain = num / env_level;
        end
        if (env_level > NOISE_FLOOR)
            gain = (gain * longint'(cur_cfg.makeup_gain)) >>> 12;

        o = round_q16(y * gain);
        lim = longint'(cur_cfg.limit_level) * UNIT;
        if (o > lim)
            o = lim;
        else if (o < -lim)
            o = -lim;

        scaled = o * 32767;
        o = (scaled >= 0) ? (scaled >>> FRAC) : -((-scaled) >>> FRAC);
        if (o > 32767)
            o = 32767;
        else if (o < -32768)
            o = -32768;
        r.sample_out = o[15:0];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        hcl_pkg::out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: sample_out %0d frame_end_out %0b",
                       out_data.sample_out, out_data.frame_end_out);
                fail_count = fail_count + 1;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (out_data.sample_out !== exp_r.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           exp_r.sample_out, out_data.sample_out);
                    fail_count = fail_count + 1;
                end
                if (out_data.frame_end_out !== exp_r.frame_end_out)
                begin
                    $error("frame_end_out: expected %0b, got %0b",
                           exp_r.frame_end_out, out_data.frame_end_out);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_sample(input logic signed [15:0] smp, input logic fe);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= hcl_pkg::in_t'{sample_in: smp, frame_end: fe};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(process_sample(hcl_pkg::in_t'{sample_in: smp, frame_end: fe}));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input hcl_pkg::cfg_idx_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            hcl_pkg::CFG_ENABLE:    cur_cfg.enable = val[0];
            hcl_pkg::CFG_HPF_ALPHA: cur_cfg.hpf_alpha = val;
            hcl_pkg::CFG_ATTACK:    cur_cfg.attack_coeff = val;
            hcl_pkg::CFG_RELEASE:   cur_cfg.release_coeff = val;
            hcl_pkg::CFG_THRESHOLD: cur_cfg.threshold = val;
            hcl_pkg::CFG_INV_RATIO: cur_cfg.inv_ratio = val;
            hcl_pkg::CFG_MAKEUP:    cur_cfg.makeup_gain = val;
            hcl_pkg::CFG_LIMIT:     cur_cfg.limit_level = val;
            default:                ;
        endcase
        @(negedge clk);
    endtask

    // only while the block is idle
    task automatic load_settings(input hcl_pkg::cfg_t c);
        write_reg(hcl_pkg::CFG_ENABLE, {15'd0, c.enable});
        write_reg(hcl_pkg::CFG_HPF_ALPHA, c.hpf_alpha);
        write_reg(hcl_pkg::CFG_ATTACK, c.attack_coeff);
        write_reg(hcl_pkg::CFG_RELEASE, c.release_coeff);
        write_reg(hcl_pkg::CFG_THRESHOLD, c.threshold);
        write_reg(hcl_pkg::CFG_INV_RATIO, c.inv_ratio);
        write_reg(hcl_pkg::CFG_MAKEUP, c.makeup_gain);
        write_reg(hcl_pkg::CFG_LIMIT, c.limit_level);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic hcl_pkg::cfg_t random_settings(input logic en);
        hcl_pkg::cfg_t c;
        c.enable = en;
        c.hpf_alpha = 16'($urandom_range(0, 65535));
        c.attack_coeff = 16'($urandom_range(0, 65535));
        c.release_coeff = 16'($urandom_range(0, 65535));
        c.threshold = 16'($urandom_range(0, 65535));
        c.inv_ratio = 16'($urandom_range(0, 65535));
        c.makeup_gain = 16'($urandom_range(0, 65535));
        c.limit_level = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // full range, quiet, and near full scale
    task automatic send_random(input int count);
        logic signed [15:0] smp;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0, 1:    smp = 16'($urandom_range(0, 65535));
                2:       smp = 16'(int'($urandom_range(0, 1024)) - 512);
                default: smp = $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 15))
                                                   : 16'sh8000 + 16'($urandom_range(0, 15));
            endcase
            send_sample(smp, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_bypass();
        logic signed [15:0] vals[7] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1,
                                       16'sd1, 16'sh5555, 16'shaaaa};
        foreach (vals[i])
            send_sample(vals[i], 1'(i % 2));
        wait_drained();
    endtask

    task automatic test_processing_directed();
        logic signed [15:0] vals[14] = '{16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                                        16'sh8000, 16'sh7fff, 16'sh0000, 16'sd1,
                                        -16'sd1, 16'sd100, -16'sd100, 16'sh7fff,
                                        16'sh8000, 16'sh0000};
        hcl_pkg::cfg_t c;
        c = hcl_pkg::CFG_RESET;
        c.enable = 1'b1;
        load_settings(c);
        foreach (vals[i])
            send_sample(vals[i], 1'(i % 3 == 2));
        wait_drained();
    endtask

    task automatic test_settings_sweep();
        hcl_pkg::cfg_t sweep[6] = '{
            // enable, alpha, attack, release, threshold, inv_ratio, makeup, limit
            '{1'b1, 16'd65535, 16'd65535, 16'd0,     16'd0,     16'd0,     16'd65535, 16'd65535},
            '{1'b1, 16'd0,     16'd0,     16'd65535, 16'd65535, 16'd1,     16'd0,     16'd0},
            '{1'b1, 16'd64523, 16'd8000,  16'd500,   16'd8192,  16'd16384, 16'd8192,  16'd29000},
            '{1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd1,     16'd65535, 16'd4096,  16'd32768},
            '{1'b1, 16'd60000, 16'd30000, 16'd100,   16'd32768, 16'd0,     16'd16384, 16'd1},
            '{1'b0, 16'd1,     16'd1,     16'd1,     16'd1,     16'd1,     16'd1,     16'd1}
        };
        send_idle_pct = 20;
        recv_stall_pct = 20;
        foreach (sweep[i])
        begin
            load_settings(sweep[i]);
            send_random(30);
            wait_drained();
        end
        for (int i = 0; i < 4; i++)
        begin
            load_settings(random_settings($urandom_range(0, 3) != 0));
            send_random(30);
            wait_drained();
        end
    endtask

    task automatic test_idle_phases();
        int send_pct[4] = '{0, 80, 0, 32};
        int recv_pct[4] = '{0, 0, 80, 32};
        hcl_pkg::cfg_t c;
        for (int p = 0; p < 4; p++)
        begin
            c = random_settings(1'b1);
            c.threshold = 16'($urandom_range(0, 32768));
            c.limit_level = 16'($urandom_range(0, 32768));
            c.inv_ratio = 16'($urandom_range(1, 65535));
            load_settings(c);
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            send_random(100);
            wait_drained();
        end
    endtask

    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        send_random(40);
        wait_drained();
    endtask

    task automatic test_input_pause();
        send_idle_pct = 10;
        recv_stall_pct = 30;
        send_random(20);
        wait_drained();
        send_random(20);
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_bypass();
        test_processing_directed();
        test_settings_sweep();
        test_idle_phases();
        test_output_holdoff();
        test_input_pause();

        // late or extra results
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("highpass_compressor_limiter_top regression: pass");
        else
            $display("highpass_compressor_limiter_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/hcl_pkg.sv
src/hcl_sequencer.sv
src/hcl_datapath.sv
src/highpass_compressor_limiter_top.sv
verif/highpass_compressor_limiter_top_test.sv
